// ===== rtl/dca_pkg.sv =====
package dca_pkg;

  // Pool defaults and fixed field widths
  localparam int DEF_POOL_SIZE = 8;
  localparam int CHAIN_LEN     = 3;
  localparam int IDX_W         = 8;
  localparam int CNT_W         = 9;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_SPACE     = 2'd1,
    ST_RANGE        = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_t;

endpackage

// ===== rtl/dca_if.sv =====
interface dca_req_if import dca_pkg::*; ();
  logic             valid;
  logic             ready;
  op_t              op;
  logic [IDX_W-1:0] head_index;

  modport source (output valid, output op, output head_index, input ready);
  modport sink   (input valid, input op, input head_index, output ready);
endinterface

interface dca_rsp_if import dca_pkg::*; ();
  logic             valid;
  logic             ready;
  status_t          status;
  logic [IDX_W-1:0] first_index;
  logic [IDX_W-1:0] second_index;
  logic [IDX_W-1:0] third_index;
  logic [CNT_W-1:0] freed_count;

  modport source (output valid, output status, output first_index, output second_index,
                  output third_index, output freed_count, input ready);
  modport sink   (input valid, input status, input first_index, input second_index,
                  input third_index, input freed_count, output ready);
endinterface

// ===== rtl/descriptor_chain_allocator_core.sv =====
// Channel | Dir | Payload                                               | Handshake
// req     | in  | op, head_index                                        | valid/ready
// rsp     | out | status, first_index, second_index, third_index,       | valid/ready
//         |     | freed_count                                           |
//
// One request is processed at a time; the next is taken only back in idle.
// Allocate, after acceptance, runs three scans of the free map (one priority
// encode each) in S_ALLOC, then writes the tail link and commits in S_TAIL;
// with fewer than three free it reports no space. Free checks the head in
// S_HEAD, then takes one S_WALK step per released descriptor, the last of
// which finds no successor; each walk step is set by the single read port of
// the link memory. A bad head ends in S_HEAD. Reset is synchronous and marks
// every descriptor free; the link memory needs no clearing. A stalled
// response freezes the final step until the output register can take it.
module descriptor_chain_allocator_core import dca_pkg::*; #(
  parameter int POOL_SIZE = DEF_POOL_SIZE
) (
  input  logic           clk,
  input  logic           rst,
  dca_req_if.sink        req,
  dca_rsp_if.source      rsp
);

  localparam int IW = $clog2(POOL_SIZE);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ALLOC = 5'b00010,
    S_TAIL  = 5'b00100,
    S_HEAD  = 5'b01000,
    S_WALK  = 5'b10000
  } state_t;

  state_t state;

  // Free map in flops (reset to all free); scan is the working copy for allocate.
  logic [POOL_SIZE-1:0] free_map;
  logic [POOL_SIZE-1:0] scan;
  logic [POOL_SIZE-1:0] tail_mask;
  logic [IW-1:0]        pick [CHAIN_LEN];
  logic [1:0]           pick_cnt;
  logic [IDX_W-1:0]     head_reg;
  logic [CNT_W-1:0]     count;

  // Link memory: {has_next, link}. Only entries in use are ever read, and an
  // entry is always written by its allocation before it can be read.
  logic [IW:0]   link_mem [POOL_SIZE];
  logic [IW:0]   rd_data;
  logic          rd_has;
  logic [IW-1:0] rd_link;

  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic [IW:0]   mem_wdata;

  logic          lowest_found;
  logic [IW-1:0] lowest_idx;

  logic          head_in_range;
  logic [IW-1:0] head_idx;

  logic             finish, out_free, stall;
  status_t          res_status;
  logic [IDX_W-1:0] res_first, res_second, res_third;
  logic [CNT_W-1:0] res_count;

  assign rd_has  = rd_data[IW];
  assign rd_link = rd_data[IW-1:0];

  assign head_idx      = head_reg[IW-1:0];
  assign head_in_range = {1'b0, head_reg} < CNT_W'(POOL_SIZE);

  assign req.ready = (state == S_IDLE);
  assign out_free  = !rsp.valid || rsp.ready;
  assign stall     = finish && !out_free;

  // lowest free entry in the scan copy
  always_comb begin
    lowest_found = 1'b0;
    lowest_idx   = '0;
    for (int i = POOL_SIZE - 1; i >= 0; i--) begin
      if (scan[i]) begin
        lowest_found = 1'b1;
        lowest_idx   = IW'(i);
      end
    end
  end

  // entries taken by the chain being committed
  always_comb begin
    tail_mask = '0;
    for (int k = 0; k < CHAIN_LEN; k++) begin
      tail_mask[pick[k]] = 1'b1;
    end
  end

  always_comb begin
    finish     = 1'b0;
    res_status = ST_OK;
    res_first  = '0;
    res_second = '0;
    res_third  = '0;
    res_count  = '0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    unique case (state)
      S_IDLE: begin
      end
      S_ALLOC: begin
        if (!lowest_found) begin
          // fewer than three free: report and leave the map untouched
          finish     = 1'b1;
          res_status = ST_NO_SPACE;
        end else if (pick_cnt != 2'd0) begin
          // link the previous pick to this one; harmless if we later abort
          mem_we    = 1'b1;
          mem_waddr = pick[pick_cnt - 2'd1];
          mem_wdata = {1'b1, lowest_idx};
        end
      end
      S_TAIL: begin
        finish     = 1'b1;
        res_status = ST_OK;
        res_first  = IDX_W'(pick[0]);
        res_second = IDX_W'(pick[1]);
        res_third  = IDX_W'(pick[2]);
        mem_we     = 1'b1;
        mem_waddr  = pick[2];
        mem_wdata  = '0;
      end
      S_HEAD: begin
        if (!head_in_range) begin
          finish     = 1'b1;
          res_status = ST_RANGE;
        end else if (free_map[head_idx]) begin
          finish     = 1'b1;
          res_status = ST_ALREADY_FREE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = head_idx;
        end
      end
      S_WALK: begin
        // rd_data holds the link of the entry freed last cycle
        res_count = count;
        if (!rd_has) begin
          finish     = 1'b1;
          res_status = ST_OK;
        end else if (free_map[rd_link]) begin
          finish     = 1'b1;
          res_status = ST_ALREADY_FREE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = rd_link;
        end
      end
      default: begin
      end
    endcase
  end

  // link memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we && !stall) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re && !stall) begin
      rd_data <= link_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      free_map  <= '1;
      rsp.valid <= 1'b0;
    end else begin
      if (finish && !stall) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (!stall) begin
        unique case (state)
          S_IDLE: begin
            if (req.valid) begin
              if (req.op == OP_ALLOC) begin
                state <= S_ALLOC;
              end else begin
                state <= S_HEAD;
              end
            end
          end
          S_ALLOC: begin
            if (!lowest_found) begin
              state <= S_IDLE;
            end else if (pick_cnt == 2'(CHAIN_LEN - 1)) begin
              state <= S_TAIL;
            end
          end
          S_TAIL: begin
            free_map <= free_map & ~tail_mask;
            state    <= S_IDLE;
          end
          S_HEAD: begin
            if (finish) begin
              state <= S_IDLE;
            end else begin
              free_map[head_idx] <= 1'b1;
              state              <= S_WALK;
            end
          end
          S_WALK: begin
            if (finish) begin
              state <= S_IDLE;
            end else begin
              free_map[rd_link] <= 1'b1;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

  // working registers and response payload
  always_ff @(posedge clk) begin
    if (!stall) begin
      case (state)
        S_IDLE: begin
          scan     <= free_map;
          pick_cnt <= '0;
          head_reg <= req.head_index;
          count    <= '0;
        end
        S_ALLOC: begin
          if (lowest_found) begin
            pick[pick_cnt]    <= lowest_idx;
            scan[lowest_idx]  <= 1'b0;
            pick_cnt          <= pick_cnt + 2'd1;
          end
        end
        S_HEAD: begin
          count <= CNT_W'(1);
        end
        S_WALK: begin
          if (!finish) begin
            count <= count + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
    if (finish && !stall) begin
      rsp.status       <= res_status;
      rsp.first_index  <= res_first;
      rsp.second_index <= res_second;
      rsp.third_index  <= res_third;
      rsp.freed_count  <= res_count;
    end
  end

endmodule

// ===== tb/dca_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels, keeps its own copy of the descriptor pool and
// compares every response with the oldest outstanding prediction.
module dca_checker import dca_pkg::*; #(
  parameter int POOL_SIZE = DEF_POOL_SIZE
) (
  input  logic clk,
  input  logic rst,
  dca_req_if   req,
  dca_rsp_if   rsp,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] second;
    logic [IDX_W-1:0] third;
    logic [CNT_W-1:0] freed;
  } reply_t;

  // shadow pool
  logic             desc_free   [POOL_SIZE];
  logic [IDX_W-1:0] desc_next   [POOL_SIZE];
  logic             desc_linked [POOL_SIZE];

  reply_t awaited_replies[$];

  initial pending = 0;

  // Applies one request to the shadow pool and returns the reply it must give.
  function automatic reply_t serve_request(op_t op, logic [IDX_W-1:0] head);
    reply_t r;
    int     picks[CHAIN_LEN];
    int     found;
    int     cur;
    int     nxt;
    logic   more;
    r     = '0;
    r.status = ST_OK;
    found = 0;
    if (op == OP_ALLOC) begin
      for (int i = 0; i < POOL_SIZE && found < CHAIN_LEN; i++) begin
        if (desc_free[i]) begin
          picks[found] = i;
          found++;
        end
      end
      if (found < CHAIN_LEN) begin
        r.status = ST_NO_SPACE;
        return r;
      end
      for (int i = 0; i < CHAIN_LEN; i++) begin
        desc_free[picks[i]] = 1'b0;
        if (i + 1 < CHAIN_LEN) begin
          desc_next[picks[i]]   = IDX_W'(picks[i + 1]);
          desc_linked[picks[i]] = 1'b1;
        end else begin
          desc_next[picks[i]]   = '0;
          desc_linked[picks[i]] = 1'b0;
        end
      end
      r.first  = IDX_W'(picks[0]);
      r.second = IDX_W'(picks[1]);
      r.third  = IDX_W'(picks[2]);
      return r;
    end
    // free walk: each step releases one entry, so it ends within the pool size
    cur = int'(head);
    for (int step = 0; step <= POOL_SIZE; step++) begin
      if (cur >= POOL_SIZE) begin
        r.status = ST_RANGE;
        break;
      end
      if (desc_free[cur]) begin
        r.status = ST_ALREADY_FREE;
        break;
      end
      more             = desc_linked[cur];
      nxt              = int'(desc_next[cur]);
      desc_next[cur]   = '0;
      desc_linked[cur] = 1'b0;
      desc_free[cur]   = 1'b1;
      r.freed++;
      if (!more)
        break;
      cur = nxt;
    end
    return r;
  endfunction

  task automatic compare_field(string field, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      for (int i = 0; i < POOL_SIZE; i++) begin
        desc_free[i]   = 1'b1;
        desc_next[i]   = '0;
        desc_linked[i] = 1'b0;
      end
      awaited_replies.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (awaited_replies.size() == 0) begin
          errors++;
          $display("%0t: response transaction with none outstanding, status %0d",
                   $time, rsp.status);
        end else begin
          want = awaited_replies.pop_front();
          compare_field("status",       int'(want.status), int'(rsp.status));
          compare_field("first_index",  int'(want.first),  int'(rsp.first_index));
          compare_field("second_index", int'(want.second), int'(rsp.second_index));
          compare_field("third_index",  int'(want.third),  int'(rsp.third_index));
          compare_field("freed_count",  int'(want.freed),  int'(rsp.freed_count));
        end
      end
      if (req.valid && req.ready)
        awaited_replies.push_back(serve_request(req.op, req.head_index));
    end
    pending = awaited_replies.size();
  end

endmodule

// ===== tb/descriptor_chain_allocator_core_test.sv =====
`timescale 1ns / 100ps

module descriptor_chain_allocator_core_test;
  import dca_pkg::*;

  localparam int POOL         = DEF_POOL_SIZE;
  localparam int RANDOM_ITEMS = 900;
  // Worst case per transaction: a full-pool walk, a long sender gap and a long
  // receiver stall; the limit leaves ample headroom.
  localparam int unsigned CYCLE_LIMIT = 300_000;
  localparam int DRAIN_CYCLES = 32;

  typedef struct packed {
    logic [IDX_W-1:0] head;
    logic [IDX_W-1:0] mid;
    logic [IDX_W-1:0] tail;
  } chain_t;

  logic        clk;
  logic        rst;
  int          errors;
  int          pending;
  int unsigned cycle_count;
  int          burst_left;

  // receiver stall pattern
  logic [5:0]  stall_phase;
  logic [1:0]  stall_mode;

  // chains learnt from successful allocate responses
  chain_t live_chains[$];

  dca_req_if req ();
  dca_rsp_if rsp ();

  descriptor_chain_allocator_core #(
    .POOL_SIZE (POOL)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  dca_checker #(
    .POOL_SIZE (POOL)
  ) u_checker (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .errors  (errors),
    .pending (pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Hard stop: covers a hung handshake as well as responses that never come.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Receiver: the mode is redrawn whenever stall_phase wraps - always ready,
  // coin toss, mostly stalled, or a square wave following stall_phase[2].
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1'b1;
    if (stall_phase == '0)
      stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0: begin
        rsp.ready <= 1'b1;
      end
      2'd1: begin
        rsp.ready <= ($urandom_range(0, 1) == 1);
      end
      2'd2: begin
        rsp.ready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        rsp.ready <= stall_phase[2];
      end
    endcase
  end

  // Successful allocations: ok status and nothing released.
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready && rsp.status == ST_OK && rsp.freed_count == '0)
      live_chains.push_back({rsp.first_index, rsp.second_index, rsp.third_index});
  end

  // Drives one request transaction and waits for its acceptance. Bursts of
  // random length are separated by random gaps; a burst may run long so that
  // some stretches see no sender idling at all.
  task automatic issue(op_t op, logic [IDX_W-1:0] head);
    req.valid      <= 1'b1;
    req.op         <= op;
    req.head_index <= head;
    do @(posedge clk); while (!req.ready);
    burst_left--;
    if (burst_left <= 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 10);
    end
  endtask

  initial begin
    int     pick;
    int     slot;
    chain_t chain;

    // every input known from time zero
    rst            = 1'b1;
    req.valid      = 1'b0;
    req.op         = OP_ALLOC;
    req.head_index = '0;
    rsp.ready      = 1'b0;
    stall_phase    = '0;
    stall_mode     = '0;
    cycle_count    = 0;
    burst_left     = 4;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, lowest-first allocation makes the indices predictable.
    issue(OP_ALLOC, 8'hFF);           // 0,1,2 - head field ignored
    issue(OP_ALLOC, 8'h00);           // 3,4,5
    issue(OP_ALLOC, 8'h00);           // two left: no space
    issue(OP_FREE, 8'd4);             // middle of a chain: frees 4,5
    issue(OP_FREE, 8'd3);             // frees 3, stops on 4 already free
    issue(OP_FREE, 8'd3);             // head already free
    issue(OP_FREE, IDX_W'(POOL));     // just beyond the pool
    issue(OP_FREE, 8'hFF);            // top of the index range
    issue(OP_FREE, 8'h80);
    issue(OP_FREE, IDX_W'(POOL - 1)); // last entry, never allocated
    issue(OP_ALLOC, 8'h00);           // 3,4,5 again
    issue(OP_ALLOC, 8'h00);           // no space
    issue(OP_FREE, 8'd0);             // whole chain
    issue(OP_FREE, 8'd3);
    issue(OP_FREE, 8'd0);             // double free
    issue(OP_ALLOC, 8'h55);
    issue(OP_ALLOC, 8'hAA);
    issue(OP_FREE, 8'd5);             // tail only
    issue(OP_FREE, 8'd3);             // frees 3,4 then hits the freed tail
    issue(OP_FREE, 8'd0);             // pool empty again

    // Random part: frees of chains learnt from allocate responses, allocates,
    // partial frees that break chains and stray indices.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (live_chains.size() != 0 && pick < 50) begin
        slot  = $urandom_range(0, live_chains.size() - 1);
        chain = live_chains[slot];
        if (pick < 40) begin
          live_chains.delete(slot);
          issue(OP_FREE, chain.head);
        end else begin
          if ($urandom_range(0, 1) == 1)
            live_chains.delete(slot);
          issue(OP_FREE, ($urandom_range(0, 1) == 1) ? chain.mid : chain.tail);
        end
      end else if (pick < 85) begin
        issue(OP_ALLOC, IDX_W'($urandom));
      end else if (pick < 93) begin
        issue(OP_FREE, IDX_W'($urandom_range(0, POOL - 1)));
      end else begin
        issue(OP_FREE, IDX_W'($urandom));
      end
    end
    req.valid <= 1'b0;

    // drain, then allow for a final walk still in flight
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/dca_pkg.sv
rtl/dca_if.sv
rtl/descriptor_chain_allocator_core.sv
tb/dca_checker.sv
tb/descriptor_chain_allocator_core_test.sv
